// ===== rtl/mpei_pkg.sv =====
// ----------------------------------------------------------------------------
// mpei_pkg: shared types for the Mandelbrot escape index unit
// Controller states, datapath command and status groups, divider sizing.
// ----------------------------------------------------------------------------
package mpei_pkg;

  // Constant divider sizing: 13-bit operand (coordinate magnitude up to 8191,
  // or a 12-bit palette count), 39-bit coordinate quotient.
  localparam int DIV_OW = 13;
  localparam int DIV_QW = 39;

  typedef enum logic [1:0] {
    DIV_RE,
    DIV_IM,
    DIV_MOD
  } mpei_div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RE_GO,
    ST_RE_WAIT,
    ST_IM_GO,
    ST_IM_WAIT,
    ST_MUL,
    ST_EVAL,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_FINISH
  } mpei_state_t;

  typedef struct packed {
    logic          load_in;
    logic          div_start;
    mpei_div_sel_t div_sel;
    logic          cap_re;
    logic          cap_im;
    logic          init_z;
    logic          mul;
    logic          step;
    logic          out_load;
  } mpei_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cont;
    logic out_free;
  } mpei_sts_t;

endpackage

// ===== rtl/mpei_ifs.sv =====
// ----------------------------------------------------------------------------
// mpei_ifs: request channels of the Mandelbrot escape index unit
// Pixel position in, escape result out, iteration limit write.
// ----------------------------------------------------------------------------
interface mpei_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_column;
  logic [9:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface mpei_res_if;
  logic        valid;
  logic        ready;
  logic        escaped;
  logic [11:0] iteration_count;
  logic [7:0]  palette_index;

  modport source (output valid, output escaped, output iteration_count,
                  output palette_index, input ready);
  modport sink   (input valid, input escaped, input iteration_count,
                  input palette_index, output ready);
endinterface

interface mpei_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] max_iterations;

  modport source (output valid, output max_iterations, input ready);
  modport sink   (input valid, input max_iterations, output ready);
endinterface

// ===== rtl/mpei_div.sv =====
// ----------------------------------------------------------------------------
// mpei_div: divider by the image width and the palette size
// Reciprocal multiply: partial products are registered, then the results;
// quotient and remainder hold once busy drops.
// ----------------------------------------------------------------------------
module mpei_div
  import mpei_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int PALETTE_SIZE = 129
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mod_op,
  input  logic [DIV_OW-1:0] operand,
  output logic              busy,
  output logic [DIV_QW-1:0] quotient,
  output logic [7:0]        remainder
);

  // floor(a * 2^29 / W) = (a * ceil(2^54 / W)) >> 25 for a up to 2^13.
  localparam logic [63:0] RECIP_W =
    ((64'd1 << 54) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH);
  localparam logic [25:0] RECIP_W_LO = RECIP_W[25:0];
  localparam logic [24:0] RECIP_W_HI = RECIP_W[50:26];
  // floor(a / P) = (a * ceil(2^20 / P)) >> 20 for a below 2^12.
  localparam logic [63:0] RECIP_P =
    ((64'd1 << 20) + 64'(PALETTE_SIZE) - 64'd1) / 64'(PALETTE_SIZE);
  localparam logic [25:0] RECIP_P_LO = RECIP_P[25:0];
  localparam logic [8:0]  PALETTE_C  = 9'(PALETTE_SIZE);

  logic [1:0]        count;
  logic              mod_q;
  logic [DIV_OW-1:0] opnd;
  logic [25:0]       lo_factor;
  logic [38:0]       p_lo;
  logic [37:0]       p_hi;
  logic [63:0]       prod;
  logic [11:0]       pal_q;
  logic [20:0]       pal_back;
  logic [20:0]       pal_rem;

  always_comb begin
    lo_factor = mod_q ? RECIP_P_LO : RECIP_W_LO;
    prod      = {p_hi, 26'b0} + 64'(p_lo);
    pal_q     = prod[31:20];
    pal_back  = 21'(pal_q) * 21'(PALETTE_C);
    pal_rem   = {9'b0, opnd[11:0]} - pal_back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 2'd2;
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == 2'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // Latch the operand, then form the partial products, then the results.
  always_ff @(posedge clk) begin
    if (start) begin
      opnd  <= operand;
      mod_q <= mod_op;
    end else if (busy && count == 2'd2) begin
      p_lo <= 39'(opnd) * 39'(lo_factor);
      p_hi <= mod_q ? '0 : 38'(opnd) * 38'(RECIP_W_HI);
    end else if (busy) begin
      quotient  <= prod[DIV_QW+24:25];
      remainder <= pal_rem[7:0];
    end
  end

endmodule

// ===== rtl/mpei_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpei_ctrl: sequencer of the Mandelbrot escape index unit
// Steps one pixel through mapping, iteration, index reduction and output.
// ----------------------------------------------------------------------------
module mpei_ctrl
  import mpei_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mpei_sts_t sts,
  output mpei_cmd_t cmd
);

  mpei_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_RE_GO;
      ST_RE_GO:    state_next = ST_RE_WAIT;
      ST_RE_WAIT:  if (!sts.div_busy) state_next = ST_IM_GO;
      ST_IM_GO:    state_next = ST_IM_WAIT;
      ST_IM_WAIT:  if (!sts.div_busy) state_next = ST_MUL;
      ST_MUL:      state_next = ST_EVAL;
      ST_EVAL:     state_next = sts.cont ? ST_MUL : ST_MOD_GO;
      ST_MOD_GO:   state_next = ST_MOD_WAIT;
      ST_MOD_WAIT: if (!sts.div_busy) state_next = ST_FINISH;
      ST_FINISH:   if (sts.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_RE;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_RE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RE;
      end
      ST_RE_WAIT:  cmd.cap_re = !sts.div_busy;
      ST_IM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_IM;
      end
      ST_IM_WAIT: begin
        cmd.cap_im = !sts.div_busy;
        cmd.init_z = !sts.div_busy;
      end
      ST_MUL:      cmd.mul  = 1'b1;
      ST_EVAL:     cmd.step = sts.cont;
      ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MOD;
      end
      ST_MOD_WAIT: ;
      ST_FINISH:   cmd.out_load = sts.out_free;
      default:     ;
    endcase
  end

endmodule

// ===== rtl/mpei_datapath.sv =====
// ----------------------------------------------------------------------------
// mpei_datapath: arithmetic of the Mandelbrot escape index unit
// Point mapping, Q4.28 orbit step, escape tests, palette reduction, result.
// ----------------------------------------------------------------------------
module mpei_datapath
  import mpei_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 768,
  parameter int PALETTE_SIZE = 129
) (
  input  logic        clk,
  input  logic        rst,
  input  mpei_cmd_t   cmd,
  output mpei_sts_t   sts,
  input  logic [9:0]  pixel_column,
  input  logic [9:0]  pixel_row,
  input  logic        cfg_valid,
  input  logic [11:0] cfg_max_iterations,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_escaped,
  output logic [11:0] out_count,
  output logic [7:0]  out_index
);

  localparam logic [DIV_OW-1:0] WIDTH_C  = DIV_OW'(IMAGE_WIDTH);
  localparam logic [DIV_OW-1:0] HEIGHT_C = DIV_OW'(IMAGE_HEIGHT);
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;
  localparam logic [63:0] SMOOTH_LIMIT = 64'h1000_0000_0000_0000;
  localparam logic signed [37:0] Q_MAX_W = 38'sd2147483647;
  localparam logic signed [37:0] Q_MIN_W = -38'sd2147483648;

  function automatic logic signed [31:0] sat_q(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > Q_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Truncating quotient with sign applied, saturated to Q4.28.
  function automatic logic signed [31:0] sat_coord(input logic neg,
                                                   input logic [DIV_QW-1:0] q);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > DIV_QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
    end else begin
      r = (q > DIV_QW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : ~q[31:0] + 1'b1;
    end
    return r;
  endfunction

  logic [9:0]  col, row;
  logic [11:0] max_iterations;
  logic [11:0] n;
  logic        coord_neg;
  logic signed [31:0] cre, cim, x, y;
  logic signed [63:0] xx, yy, xy;

  // Mapping numerator (2*pos - size), sign and magnitude.
  logic [9:0]          pos;
  logic [DIV_OW-1:0]   size;
  logic signed [13:0]  d;
  logic                d_neg;
  logic [13:0]         d_abs;
  logic [DIV_OW-1:0]   dividend;
  logic                div_busy;
  logic [DIV_QW-1:0]   quotient;
  logic [7:0]          remainder;

  // Orbit step and escape tests.
  logic [63:0]        mag;
  logic signed [63:0] diff;
  logic signed [35:0] re_sh;
  logic signed [36:0] im_sh;
  logic signed [37:0] nx, ny;
  logic               smooth;
  logic [11:0]        adj;
  logic               escaped_now;

  always_comb begin
    pos  = (cmd.div_sel == DIV_IM) ? row : col;
    size = (cmd.div_sel == DIV_IM) ? HEIGHT_C : WIDTH_C;
    d     = $signed({3'b000, pos, 1'b0}) - $signed({1'b0, size});
    d_neg = d[13];
    d_abs = d_neg ? 14'(-d) : 14'(d);
    if (cmd.div_sel == DIV_MOD) begin
      dividend = {1'b0, adj};
    end else begin
      dividend = d_abs[DIV_OW-1:0];
    end
  end

  mpei_div #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .mod_op    (cmd.div_sel == DIV_MOD),
    .operand   (dividend),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    mag    = 64'(unsigned'(xx)) + 64'(unsigned'(yy));
    diff   = xx - yy;
    re_sh  = diff[63:28];
    im_sh  = xy[63:27];
    nx     = {{2{re_sh[35]}}, re_sh} + {{6{cre[31]}}, cre};
    ny     = {im_sh[36], im_sh} + {{6{cim[31]}}, cim};
    smooth = mag > SMOOTH_LIMIT;
    adj    = n - {11'b0, smooth};
    escaped_now = n < max_iterations;
  end

  assign sts.div_busy = div_busy;
  assign sts.cont     = (mag <= ESCAPE_LIMIT) && (n < max_iterations);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= 12'd1000;
    end else if (cfg_valid) begin
      max_iterations <= cfg_max_iterations;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col <= pixel_column;
      row <= pixel_row;
    end
    if (cmd.div_start) begin
      coord_neg <= d_neg;
    end
    if (cmd.cap_re) begin
      cre <= sat_coord(coord_neg, quotient);
    end
    if (cmd.cap_im) begin
      cim <= sat_coord(coord_neg, quotient);
    end
    if (cmd.init_z) begin
      x <= '0;
      y <= '0;
      n <= '0;
    end else if (cmd.step) begin
      x <= sat_q(nx);
      y <= sat_q(ny);
      n <= n + 1'b1;
    end
    if (cmd.init_z) begin
      xx <= '0;
      yy <= '0;
      xy <= '0;
    end else if (cmd.mul) begin
      xx <= x * x;
      yy <= y * y;
      xy <= x * y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_escaped <= escaped_now;
      out_count   <= n;
      out_index   <= escaped_now ? remainder : 8'd0;
    end
  end

endmodule

// ===== rtl/mandelbrot_pixel_escape_index_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_index_unit: Mandelbrot escape count and palette index
// Sequence per request: each coordinate is mapped by a reciprocal multiply by
//   the image width, then the orbit alternates a multiply step and a test step
//   (n iterations run, at most max_iterations, plus one final test), then the
//   palette reduction, then the result register is loaded.
// Pixels are taken one at a time; the next request is taken while
//   a finished result still waits in the output register.
// Reset: synchronous, clears the sequencer and output valid, max_iterations 1000.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_index_unit
  import mpei_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 768,
  parameter int PALETTE_SIZE = 129
) (
  input  logic       clk,
  input  logic       rst,
  mpei_pix_if.sink   pixel,
  mpei_res_if.source result,
  mpei_cfg_if.sink   cfg
);

  mpei_cmd_t cmd;
  mpei_sts_t sts;

  // The limit register takes a write in any cycle; writes must arrive only when idle, which the block does not enforce.
  assign cfg.ready = 1'b1;

  // Sequencer: accepts a pixel request in IDLE, then walks the datapath through
  // mapping, orbit iteration, palette reduction and result load.
  mpei_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds c, z, products, count, shared divider and result register.
  mpei_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .pixel_column       (pixel.pixel_column),
    .pixel_row          (pixel.pixel_row),
    .cfg_valid          (cfg.valid),
    .cfg_max_iterations (cfg.max_iterations),
    .out_ready          (result.ready),
    .out_valid          (result.valid),
    .out_escaped        (result.escaped),
    .out_count          (result.iteration_count),
    .out_index          (result.palette_index)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Mandelbrot escape index unit
// Drives pixel positions and iteration-limit writes, predicts escape flag,
// iteration count and palette index in Q4.28 fixed point, and checks every
// result in order; both sides idle and stall at random until the quiet tail.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IMG_W    = 1024;
  localparam int IMG_H    = 768;
  localparam int PAL_SIZE = 129;

  // Longest quiet stretch allowed: well above what one 4095-step pixel takes.
  localparam int STALL_LIMIT = 40000;

  // Q4.28 range and the |z|^2 thresholds in Q8.56.
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint unsigned ESCAPE_MAG = 64'h0400_0000_0000_0000;
  localparam longint unsigned SMOOTH_MAG = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic        escaped;
    logic [11:0] count;
    logic [7:0]  palette;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst;

  mpei_pix_if pix ();
  mpei_res_if res ();
  mpei_cfg_if cfg_bus ();

  mandelbrot_pixel_escape_index_unit #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H),
    .PALETTE_SIZE (PAL_SIZE)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (res),
    .cfg    (cfg_bus)
  );

  always #5 clk = ~clk;

  // Local copy of the iteration limit, updated when a write is accepted.
  logic [11:0]    iter_limit;
  // Predicted results, oldest first.
  escape_result_t pending_escapes[$];
  escape_result_t head;
  // Set for the final stretch: no gaps on the pixel side, no stalls on results.
  bit             quiet;

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned pixels_sent;
  int unsigned escaped_sent;
  int unsigned wrapped_sent;
  int unsigned limits_written;
  int unsigned idle_cycles;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Saturate to the Q4.28 range.
  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Map a pixel position to Q4.28: (2*pos - span) * 2^29 / width, truncated
  // toward zero.
  function automatic longint pixel_to_q(longint pos, longint span);
    longint num;
    num = (pos * 2 - span) * (longint'(1) <<< 29);
    return clamp_q(num / IMG_W);
  endfunction

  // Run the orbit of one pixel under the current limit.
  function automatic escape_result_t predict_escape(input logic [9:0] col,
                                                    input logic [9:0] row);
    escape_result_t r;
    longint cr, ci, zr, zi, ar, ai;
    longint unsigned mag, ur, ui;
    int unsigned steps, adj;
    cr = pixel_to_q(longint'(col), IMG_W);
    ci = pixel_to_q(longint'(row), IMG_H);
    zr = 0;
    zi = 0;
    mag = 0;
    steps = 0;
    while (mag <= ESCAPE_MAG && steps < iter_limit) begin
      // Floor shifts: 28 for x*x - y*y, 27 for x*y to get 2*x*y.
      ar = ((zr * zr - zi * zi) >>> 28) + cr;
      ai = ((zr * zi) >>> 27) + ci;
      zr = clamp_q(ar);
      zi = clamp_q(ai);
      steps++;
      ur = (zr < 0) ? -zr : zr;
      ui = (zi < 0) ? -zi : zi;
      mag = ur * ur + ui * ui;
    end
    // Reaching the limit counts as inside, even if the last step escaped.
    r.escaped = (steps < iter_limit);
    r.count   = 12'(steps);
    adj       = steps - ((mag > SMOOTH_MAG) ? 1 : 0);
    r.palette = r.escaped ? 8'(adj % PAL_SIZE) : 8'd0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request drivers
  // --------------------------------------------------------------------------

  // Send one pixel request; leave valid high after acceptance so that a
  // back-to-back request never drops and raises it in the same step.
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    escape_result_t want;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix.valid        <= 1'b1;
    pix.pixel_column <= col;
    pix.pixel_row    <= row;
    do @(posedge clk); while (!pix.ready);
    want = predict_escape(col, row);
    pending_escapes.push_back(want);
    pixels_sent++;
    if (want.escaped) begin
      escaped_sent++;
      if (want.count >= PAL_SIZE) wrapped_sent++;
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic end_batch();
    pix.valid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
  endtask

  // Write the iteration limit; only called while the unit is idle.
  task automatic write_limit(input logic [11:0] v);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.max_iterations <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    iter_limit = v;
    limits_written++;
  endtask

  // Mostly uniform over the whole field, part of it inside the window that
  // holds the body of the set, where orbits run long.
  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      else
        send_pixel(10'($urandom_range(200, 600)), 10'($urandom_range(200, 568)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limit of 1000, no write yet.
  task automatic test_reset_limit();
    send_pixel(10'd512, 10'd384);   // c = 0: inside, runs to the limit
    send_pixel(10'd0, 10'd384);     // c = -2: |z|^2 sits at exactly 4, no escape
    send_pixel(10'd320, 10'd385);   // neck of the set: long orbit, index wraps
    send_pixel(10'd1023, 10'd1023); // far corner: escapes on the first step
    send_pixel(10'd1023, 10'd384);  // escapes on the second step
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd0);
    end_batch();
  endtask

  // Limit 1: nothing can count as escaped.
  task automatic test_single_step();
    write_limit(12'd1);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd0, 10'd0);
    end_batch();
  endtask

  // Limit 2: an escape on the second step lands on the limit and reads inside.
  task automatic test_last_step_escape();
    write_limit(12'd2);
    send_pixel(10'd1023, 10'd384);
    send_pixel(10'd1023, 10'd1023);
    end_batch();
  endtask

  // Limit 0: no step is run at all.
  task automatic test_zero_limit();
    write_limit(12'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd384);
    end_batch();
  endtask

  // Largest limit: longest orbits and counts far past the palette size.
  task automatic test_full_limit();
    write_limit(12'd4095);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd320, 10'd385);
    send_pixel(10'd1023, 10'd1023);
    end_batch();
  endtask

  // Random pixels under a series of limits; keep most limits small so the run
  // stays short, with one sweep around the palette size and one over all 12 bits.
  task automatic test_random_sweeps();
    for (int sweep = 0; sweep < 10; sweep++) begin
      if (sweep == 3)
        write_limit(12'($urandom_range(100, 300)));
      else if (sweep == 6)
        write_limit(12'($urandom_range(1, 4095)));
      else
        write_limit(12'($urandom_range(1, 64)));
      send_random_pixels(sweep == 6 ? 20 : 60);
      end_batch();
    end
  endtask

  // Last stretch at full rate: no gaps and no stalls.
  task automatic test_quiet_tail();
    write_limit(12'($urandom_range(1, 64)));
    quiet = 1'b1;
    send_random_pixels(50);
    end_batch();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls of ready
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        res.ready <= 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        res.ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (pending_escapes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing pending: escaped=%0d count=%0d palette=%0d",
                   $realtime, res.escaped, res.iteration_count, res.palette_index);
      end else begin
        head = pending_escapes.pop_front();
        if (res.escaped !== head.escaped || res.iteration_count !== head.count ||
            res.palette_index !== head.palette) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"%0t: mismatch: expected escaped=%0d count=%0d palette=%0d,",
                      " got escaped=%0d count=%0d palette=%0d"},
                     $realtime, head.escaped, head.count, head.palette,
                     res.escaped, res.iteration_count, res.palette_index);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no request moves on any channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_escapes.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                    <= 1'b1;
    pix.valid              <= 1'b0;
    pix.pixel_column       <= '0;
    pix.pixel_row          <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.max_iterations <= '0;
    iter_limit     = 12'd1000;
    quiet          = 1'b0;
    fail_count     = 0;
    results_seen   = 0;
    pixels_sent    = 0;
    escaped_sent   = 0;
    wrapped_sent   = 0;
    limits_written = 0;
    idle_cycles    = 0;

    // Hold reset, then release it for good.
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_limit();
    test_single_step();
    test_last_step_escape();
    test_zero_limit();
    test_full_limit();
    test_random_sweeps();
    test_quiet_tail();

    // Give a stray result time to show up after the last one.
    repeat (300) @(posedge clk);

    $display({"checked %0d results for %0d pixels: %0d escaped,",
              " %0d with counts past the palette size"},
             results_seen, pixels_sent, escaped_sent, wrapped_sent);
    $display("iteration limit written %0d times, including 0, 1, 2 and 4095",
             limits_written);
    if (fail_count == 0 && pending_escapes.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
